// ===== rtl/vvfe_pkg.sv =====
// Shared types and constants of the voxel volume fill engine.
// No dependencies; used by vvfe_hit_pipe and voxel_volume_fill_engine_unit.
package vvfe_pkg;

  // Default edge length of the volume store.
  localparam int unsigned DIM_MAX_DEF = 32;

  // Fixed field widths.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned FILL_W  = 12;
  localparam int unsigned VOX_W   = 8;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Radius squares and their products (radius magnitude at most 128).
  localparam int unsigned RSQ_W = 15;
  localparam int unsigned RPR_W = 29;
  localparam int unsigned RTR_W = 43;

  localparam logic [VOX_W-1:0] VOX_RESET = 8'd99;
  localparam logic [VOX_W-1:0] VOX_SAT   = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE     = 3'd0,
    CMD_READ      = 3'd1,
    CMD_SPHERE    = 3'd2,
    CMD_ELLIPSOID = 3'd3,
    CMD_BOX       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_POINT,
    MODE_SPHERE,
    MODE_ELLIPSOID,
    MODE_BOX
  } mode_t;

  // Shape description held for the length of one command.
  typedef struct packed {
    mode_t                     mode;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] c;
    logic [RSQ_W-1:0]          ra;
    logic [RSQ_W-1:0]          rb;
    logic [RSQ_W-1:0]          rc;
    logic [RPR_W-1:0]          rab;
    logic [RPR_W-1:0]          rac;
    logic [RPR_W-1:0]          rbc;
    logic [RTR_W-1:0]          rabc;
    logic                      ell_zero;
  } shape_t;

  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } pipe_res_t;

endpackage

// ===== rtl/vvfe_hit_pipe.sv =====
// Three-stage cell test and address pipeline of the voxel volume fill engine.
// Depends on vvfe_pkg (shape_t, pipe_ctl_t, pipe_res_t, mode_t).
module vvfe_hit_pipe #(
  parameter int unsigned DIM_MAX = vvfe_pkg::DIM_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  vvfe_pkg::pipe_ctl_t                   in_ctl,
  input  logic [$clog2(DIM_MAX)-1:0]            x,
  input  logic [$clog2(DIM_MAX)-1:0]            y,
  input  logic [$clog2(DIM_MAX)-1:0]            z,
  input  logic [$clog2(DIM_MAX+1)-1:0]          nx,
  input  logic [2*$clog2(DIM_MAX+1)-1:0]        nxny,
  input  vvfe_pkg::shape_t                      shape,
  output vvfe_pkg::pipe_res_t                   out_res,
  output logic [$clog2(DIM_MAX**3)-1:0]         addr
);
  import vvfe_pkg::*;

  localparam int unsigned IW     = $clog2(DIM_MAX);
  localparam int unsigned AW     = $clog2(DIM_MAX**3);
  localparam int unsigned DW     = ((IW + 1 > COORD_W) ? IW + 1 : COORD_W) + 1;
  localparam int unsigned SQ_W   = 2 * DW;
  localparam int unsigned SSUM_W = SQ_W + 2;
  localparam int unsigned TERM_W = SQ_W + RPR_W;
  localparam int unsigned SUM_W  = TERM_W + 2;

  // Stage 1: offsets, squares, box test, address partial products.
  logic signed [DW-1:0]   xs, ys, zs, dx, dy, dz;
  logic signed [SQ_W-1:0] dxe, dye, dze;
  logic signed [SQ_W-1:0] sqx_s, sqy_s, sqz_s;
  logic                   box_comb;

  assign xs  = signed'({{(DW-IW){1'b0}}, x});
  assign ys  = signed'({{(DW-IW){1'b0}}, y});
  assign zs  = signed'({{(DW-IW){1'b0}}, z});
  assign dx  = xs - DW'(shape.cx);
  assign dy  = ys - DW'(shape.cy);
  assign dz  = zs - DW'(shape.cz);
  assign dxe = SQ_W'(dx);
  assign dye = SQ_W'(dy);
  assign dze = SQ_W'(dz);
  assign sqx_s = dxe * dxe;
  assign sqy_s = dye * dye;
  assign sqz_s = dze * dze;
  assign box_comb = (xs >= DW'(shape.cx)) && (xs <= DW'(shape.a)) &&
                    (ys >= DW'(shape.cy)) && (ys <= DW'(shape.b)) &&
                    (zs >= DW'(shape.cz)) && (zs <= DW'(shape.c));

  pipe_ctl_t         ctl1;
  logic [SQ_W-1:0]   sqx1, sqy1, sqz1;
  logic              box1;
  logic [AW-1:0]     pz1, py1, px1;

  // Stage 2: sphere sum, ellipsoid terms, address sum.
  pipe_ctl_t         ctl2;
  logic [TERM_W-1:0] tx2, ty2, tz2;
  logic              sph2, box2;
  logic [AW-1:0]     addr2;
  logic [SSUM_W-1:0] ssum;

  assign ssum = SSUM_W'(sqx1) + SSUM_W'(sqy1) + SSUM_W'(sqz1);

  // Stage 3: ellipsoid sum and compare, pick the test of the mode.
  logic [SUM_W-1:0]  esum;
  logic              ell_hit, hit_comb;

  assign esum    = SUM_W'(tx2) + SUM_W'(ty2) + SUM_W'(tz2);
  assign ell_hit = !shape.ell_zero && (esum <= SUM_W'(shape.rabc));

  always_comb begin
    case (shape.mode)
      MODE_POINT:     hit_comb = 1'b1;
      MODE_SPHERE:    hit_comb = sph2;
      MODE_ELLIPSOID: hit_comb = ell_hit;
      MODE_BOX:       hit_comb = box2;
      default:        hit_comb = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      out_res <= '0;
    end else begin
      ctl1    <= in_ctl;
      ctl2    <= ctl1;
      out_res <= '{valid: ctl2.valid, last: ctl2.last, hit: hit_comb};
    end
    sqx1  <= $unsigned(sqx_s);
    sqy1  <= $unsigned(sqy_s);
    sqz1  <= $unsigned(sqz_s);
    box1  <= box_comb;
    pz1   <= AW'(z) * AW'(nxny);
    py1   <= AW'(y) * AW'(nx);
    px1   <= AW'(x);
    tx2   <= TERM_W'(sqx1) * TERM_W'(shape.rbc);
    ty2   <= TERM_W'(sqy1) * TERM_W'(shape.rac);
    tz2   <= TERM_W'(sqz1) * TERM_W'(shape.rab);
    sph2  <= ssum < SSUM_W'(shape.ra);
    box2  <= box1;
    addr2 <= pz1 + py1 + px1;
    addr  <= addr2;
  end

endmodule

// ===== rtl/voxel_volume_fill_engine_unit.sv =====
// Top level of the voxel volume fill engine: command sequencer, voxel store
// and configuration registers. Depends on vvfe_pkg and vvfe_hit_pipe.
//
//  channel   | signals                              | carries
//  ----------+--------------------------------------+---------------------------------
//  command   | s_axis_tvalid/tready/tdata/tuser     | one request: opcode and operands
//  result    | m_axis_tvalid/tready/tdata           | read data and range status
//  config    | cfg_we/cfg_index/cfg_data            | size_x, size_y, size_z
//
// Sequence: an in-range point request scans its one cell; a fill first runs the
// setup states PREP_SQ, PREP_PROD and PREP_TRIPLE, then scans each cell of the
// volume in use (nx*ny*nz, 32768 at the default size), then drains the pipeline.
// The single write port of the voxel store sets the scan rate: one cell a cycle.
// Reset: rst is synchronous. After it a clearing pass writes 99 to every cell,
// all DIM_MAX**3 of them (32768 by default); no request is taken until it ends.
// Stalls: a result waits in the output register while the next request is
// taken; the sequencer holds a finished result only if that register is full.
module voxel_volume_fill_engine_unit #(
  parameter int unsigned DIM_MAX = vvfe_pkg::DIM_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // coord_x [7:0], coord_y [15:8], coord_z [23:16], arg_a [31:24],
  // arg_b [39:32], arg_c [47:40], fill_value [59:48], zero [63:60]
  input  logic [63:0]                       s_axis_tdata,
  // command [2:0]
  input  logic [2:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_data [7:0], status [8], zero [15:9]
  output logic [15:0]                       m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [vvfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vvfe_pkg::CFG_W-1:0]        cfg_data
);
  import vvfe_pkg::*;

  localparam int unsigned IW    = $clog2(DIM_MAX);
  localparam int unsigned SW    = $clog2(DIM_MAX + 1);
  localparam int unsigned DEPTH = DIM_MAX ** 3;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP_SQ,
    ST_PREP_PROD,
    ST_PREP_TRIPLE,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers and effective sizes
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] size_x, size_y, size_z;
  logic [SW-1:0]    nx, ny, nz;
  logic [2*SW-1:0]  nxny;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= CFG_W'(32);
      size_y <= CFG_W'(32);
      size_z <= CFG_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Clamp each size into 1..DIM_MAX.
  always_comb begin
    if (size_x == '0)                          nx = SW'(1);
    else if ((CFG_W+1)'(size_x) > (CFG_W+1)'(DIM_MAX)) nx = SW'(DIM_MAX);
    else                                       nx = SW'(size_x);
    if (size_y == '0)                          ny = SW'(1);
    else if ((CFG_W+1)'(size_y) > (CFG_W+1)'(DIM_MAX)) ny = SW'(DIM_MAX);
    else                                       ny = SW'(size_y);
    if (size_z == '0)                          nz = SW'(1);
    else if ((CFG_W+1)'(size_z) > (CFG_W+1)'(DIM_MAX)) nz = SW'(DIM_MAX);
    else                                       nz = SW'(size_z);
  end

  // Registered plane size; the user must change sizes only while idle (unchecked).
  always_ff @(posedge clk) begin
    nxny <= (2*SW)'(nx) * (2*SW)'(ny);
  end

  // ---------------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------------
  logic [CMD_W-1:0]   in_cmd;
  logic [COORD_W-1:0] in_cx, in_cy, in_cz, in_a, in_b, in_c;
  logic [FILL_W-1:0]  in_fill;
  logic               in_range;
  logic               accept;

  assign in_cmd  = s_axis_tuser[CMD_W-1:0];
  assign in_cx   = s_axis_tdata[7:0];
  assign in_cy   = s_axis_tdata[15:8];
  assign in_cz   = s_axis_tdata[23:16];
  assign in_a    = s_axis_tdata[31:24];
  assign in_b    = s_axis_tdata[39:32];
  assign in_c    = s_axis_tdata[47:40];
  assign in_fill = s_axis_tdata[59:48];

  // Point in range: non-negative and below the size on every axis.
  assign in_range = !in_cx[COORD_W-1] && (in_cx < COORD_W'(nx)) &&
                    !in_cy[COORD_W-1] && (in_cy < COORD_W'(ny)) &&
                    !in_cz[COORD_W-1] && (in_cz < COORD_W'(nz));

  assign accept = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t            state;
  logic [CMD_W-1:0]  cmd;
  logic [VOX_W-1:0]  fill_val;
  shape_t            shape;
  logic [IW-1:0]     scan_x, scan_y, scan_z;
  logic [AW-1:0]     clr_addr;
  logic [VOX_W-1:0]  res_data;
  logic              res_status;
  logic [VOX_W-1:0]  out_data;
  logic              out_status;
  logic              out_valid;

  // Radius squares and their products, one multiply level per setup cycle.
  logic [COORD_W-1:0]   mag_a, mag_b, mag_c;
  logic [2*COORD_W-1:0] sq_a, sq_b, sq_c;
  logic [2*RSQ_W-1:0]   pr_ab, pr_ac, pr_bc;
  logic [RPR_W+RSQ_W-1:0] pr_abc;

  assign mag_a  = shape.a[COORD_W-1] ? COORD_W'(-shape.a) : shape.a;
  assign mag_b  = shape.b[COORD_W-1] ? COORD_W'(-shape.b) : shape.b;
  assign mag_c  = shape.c[COORD_W-1] ? COORD_W'(-shape.c) : shape.c;
  assign sq_a   = (2*COORD_W)'(mag_a) * (2*COORD_W)'(mag_a);
  assign sq_b   = (2*COORD_W)'(mag_b) * (2*COORD_W)'(mag_b);
  assign sq_c   = (2*COORD_W)'(mag_c) * (2*COORD_W)'(mag_c);
  assign pr_ab  = (2*RSQ_W)'(shape.ra) * (2*RSQ_W)'(shape.rb);
  assign pr_ac  = (2*RSQ_W)'(shape.ra) * (2*RSQ_W)'(shape.rc);
  assign pr_bc  = (2*RSQ_W)'(shape.rb) * (2*RSQ_W)'(shape.rc);
  assign pr_abc = (RPR_W+RSQ_W)'(shape.rab) * (RPR_W+RSQ_W)'(shape.rc);

  // Scan position: z runs fastest, then y, then x.
  logic z_end, y_end, x_end, point_cmd, scan_last;

  assign z_end     = (SW'(scan_z) == nz - SW'(1));
  assign y_end     = (SW'(scan_y) == ny - SW'(1));
  assign x_end     = (SW'(scan_x) == nx - SW'(1));
  assign point_cmd = (shape.mode == MODE_POINT);
  assign scan_last = point_cmd || (z_end && y_end && x_end);

  // ---------------------------------------------------------------------------
  // Cell test pipeline
  // ---------------------------------------------------------------------------
  pipe_ctl_t     pipe_ctl;
  pipe_res_t     pipe_res;
  logic [AW-1:0] pipe_addr;

  assign pipe_ctl = '{valid: (state == ST_SCAN), last: scan_last};

  vvfe_hit_pipe #(
    .DIM_MAX (DIM_MAX)
  ) u_hit_pipe (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (pipe_ctl),
    .x       (scan_x),
    .y       (scan_y),
    .z       (scan_z),
    .nx      (nx),
    .nxny    (nxny),
    .shape   (shape),
    .out_res (pipe_res),
    .addr    (pipe_addr)
  );

  // ---------------------------------------------------------------------------
  // Voxel store: one write or one read per cycle, registered read data
  // ---------------------------------------------------------------------------
  logic [VOX_W-1:0] mem [DEPTH];
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [VOX_W-1:0] mem_wdata;
  logic [VOX_W-1:0] rd_data;

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = VOX_RESET;
    end else begin
      mem_we    = pipe_res.valid && pipe_res.hit && (cmd != CMD_READ);
      mem_waddr = pipe_addr;
      mem_wdata = fill_val;
    end
  end

  assign mem_re = pipe_res.valid && (cmd == CMD_READ);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[pipe_addr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(16-VOX_W-1){1'b0}}, out_status, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      scan_x    <= '0;
      scan_y    <= '0;
      scan_z    <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken; the done step loads the next one itself.
      if (out_valid && m_axis_tready && state != ST_DONE) out_valid <= 1'b0;

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= ST_IDLE;
        end

        ST_IDLE: begin
          if (accept) begin
            cmd        <= in_cmd;
            fill_val   <= (in_fill > FILL_W'(VOX_SAT)) ? VOX_SAT : in_fill[VOX_W-1:0];
            shape.cx   <= in_cx;
            shape.cy   <= in_cy;
            shape.cz   <= in_cz;
            shape.a    <= in_a;
            shape.b    <= in_b;
            shape.c    <= in_c;
            shape.ell_zero <= (in_a == '0) || (in_b == '0) || (in_c == '0);
            res_data   <= '0;
            res_status <= 1'b0;
            case (in_cmd)
              CMD_WRITE, CMD_READ: begin
                shape.mode <= MODE_POINT;
                if (in_range) begin
                  scan_x <= in_cx[IW-1:0];
                  scan_y <= in_cy[IW-1:0];
                  scan_z <= in_cz[IW-1:0];
                  state  <= ST_SCAN;
                end else begin
                  // Out-of-range point: flag it and touch nothing.
                  res_status <= 1'b1;
                  state      <= ST_DONE;
                end
              end
              CMD_SPHERE: begin
                shape.mode <= MODE_SPHERE;
                state      <= ST_PREP_SQ;
              end
              CMD_ELLIPSOID: begin
                shape.mode <= MODE_ELLIPSOID;
                state      <= ST_PREP_SQ;
              end
              CMD_BOX: begin
                shape.mode <= MODE_BOX;
                state      <= ST_PREP_SQ;
              end
              default: state <= ST_DONE;
            endcase
          end
        end

        ST_PREP_SQ: begin
          shape.ra <= sq_a[RSQ_W-1:0];
          shape.rb <= sq_b[RSQ_W-1:0];
          shape.rc <= sq_c[RSQ_W-1:0];
          state    <= ST_PREP_PROD;
        end

        ST_PREP_PROD: begin
          shape.rab <= pr_ab[RPR_W-1:0];
          shape.rac <= pr_ac[RPR_W-1:0];
          shape.rbc <= pr_bc[RPR_W-1:0];
          state     <= ST_PREP_TRIPLE;
        end

        ST_PREP_TRIPLE: begin
          shape.rabc <= pr_abc[RTR_W-1:0];
          state      <= ST_SCAN;
        end

        ST_SCAN: begin
          // Issue one cell a cycle; park the scan at the origin after the last.
          if (scan_last) begin
            scan_x <= '0;
            scan_y <= '0;
            scan_z <= '0;
            state  <= ST_DRAIN;
          end else if (!z_end) begin
            scan_z <= scan_z + IW'(1);
          end else begin
            scan_z <= '0;
            if (!y_end) begin
              scan_y <= scan_y + IW'(1);
            end else begin
              scan_y <= '0;
              scan_x <= scan_x + IW'(1);
            end
          end
        end

        ST_DRAIN: begin
          if (pipe_res.valid && pipe_res.last) begin
            state <= (cmd == CMD_READ) ? ST_READ : ST_DONE;
          end
        end

        ST_READ: begin
          res_data <= rd_data;
          state    <= ST_DONE;
        end

        ST_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_data   <= res_data;
            out_status <= res_status;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pipe_only_busy: assert property (@(posedge clk) disable iff (rst)
    pipe_res.valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("cell pipeline produced a cell outside a command");

  a_read_follows_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> $past(mem_re))
    else $error("read result captured without a store read");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DONE))
    else $error("result presented outside the done step");

  a_scan_parked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (scan_x == '0 && scan_y == '0 && scan_z == '0))
    else $error("scan position not at origin while idle");

endmodule
